// ===== src/fts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fts_pkg
// Shared widths, reset values and register codes of the frame time smoother.
// ----------------------------------------------------------------------------
package fts_pkg;

    localparam int HISTORY_DEPTH = 8;    // power of two, 2 to 64
    localparam int TICK_BITS     = 48;
    localparam int DATA_BITS     = 32;
    localparam int POS_BITS      = $clog2(HISTORY_DEPTH);
    localparam int SUM_BITS      = DATA_BITS + POS_BITS;
    localparam int CMP_BITS      = (TICK_BITS > DATA_BITS) ? TICK_BITS : DATA_BITS;
    localparam int ELAPSED_BITS  = 64;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [DATA_BITS-1:0] PEAK_RESET    = DATA_BITS'(200000);
    localparam logic [DATA_BITS-1:0] DEFAULT_RESET = DATA_BITS'(30000);

    localparam logic [CFG_INDEX_BITS-1:0] REG_PEAK_LIMIT       = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEFAULT_DURATION = 1'b1;

    localparam logic ACTION_RESTART = 1'b0;
    localparam logic ACTION_FRAME   = 1'b1;

endpackage

// ===== src/fts_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fts_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/frame_time_smoother_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_time_smoother_unit
// Smoothed frame clock: mean of the last frame durations, with spike rejection.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries action and tick. A restart
// refills the history with default_duration and zeroes elapsed time and
// frame count; a frame boundary measures the ticks since the last event,
// replaces a duration above peak_limit by the newest stored one, and
// updates the running mean, the elapsed time and the frame count.
// Output channel (out_valid/out_ready) returns one result per transaction.
// out_valid rises as the working stage hands over its result. Throughput
// is one transaction per cycle while results are taken: the history RAM
// is read at accept and written as the working stage passes on, and the
// next read after a frame is of the following entry: no read/write conflict.
// A full output register that is not taken holds the working stage, and
// in_ready drops until the result leaves.
// Reset (rst_n, asynchronous) gives the restart state with the reset
// defaults; the history RAM is covered by per-entry valid bits, so no
// clearing pass is needed. Configuration writes via cfg_write_en,
// cfg_index, cfg_data take effect at once; a new default applies from
// the next restart.
// ----------------------------------------------------------------------------
module frame_time_smoother_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write_en,
    input  logic [fts_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [fts_pkg::DATA_BITS-1:0]          cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   action,
    input  logic [fts_pkg::TICK_BITS-1:0]          tick,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [fts_pkg::DATA_BITS-1:0]          predicted_duration,
    output logic [fts_pkg::ELAPSED_BITS-1:0]       elapsed_time,
    output logic [fts_pkg::DATA_BITS-1:0]          frame_count,
    output logic                                   spike_replaced
);

    localparam int DEPTH = fts_pkg::HISTORY_DEPTH;
    localparam int DW    = fts_pkg::DATA_BITS;
    localparam int PW    = fts_pkg::POS_BITS;
    localparam int SW    = fts_pkg::SUM_BITS;
    localparam int TW    = fts_pkg::TICK_BITS;
    localparam int CW    = fts_pkg::CMP_BITS;
    localparam int EW    = fts_pkg::ELAPSED_BITS;
    localparam logic [PW-1:0] LAST_POS = PW'(DEPTH - 1);

    // configuration
    logic [DW-1:0] peak_limit_reg;
    logic [DW-1:0] default_duration_reg;

    // accept side
    logic [PW-1:0] pos_reg, pos_next;
    logic [TW-1:0] prev_tick_reg;
    logic [TW-1:0] meas;
    logic [CW-1:0] meas_ext;
    logic          accept;

    // working stage
    logic          s1_valid_reg, s1_valid_next;
    logic          s1_action_reg;
    logic [PW-1:0] s1_pos_reg;
    logic          s1_spike_reg;
    logic [DW-1:0] s1_meas_reg;
    logic          s1_go;

    // history state
    logic [DEPTH-1:0] hist_valid_reg, hist_valid_next;
    logic [DW-1:0]    fill_reg, fill_next;
    logic [DW-1:0]    newest_reg, newest_next;
    logic [SW-1:0]    window_sum_reg, window_sum_next;
    logic [DW-1:0]    ram_rd_data;
    logic [DW-1:0]    oldest;
    logic [DW-1:0]    dur;

    // results, which are also the accumulators
    logic          out_valid_reg, out_valid_next;
    logic [DW-1:0] pred_reg, pred_next;
    logic [EW-1:0] elapsed_reg, elapsed_next;
    logic [DW-1:0] count_reg, count_next;
    logic          spike_reg, spike_next;

    assign s1_go    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_go;
    assign accept   = in_valid && in_ready;

    assign meas     = tick - prev_tick_reg;
    assign meas_ext = CW'(meas);

    always_comb
    begin
        if (action == fts_pkg::ACTION_RESTART)
        begin
            pos_next = '0;
        end
        else if (pos_reg == LAST_POS)
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_reg + PW'(1);
        end
    end

    fts_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_history (
        .clk     (clk),
        .wr_en   (s1_go && (s1_action_reg == fts_pkg::ACTION_FRAME)),
        .wr_addr (s1_pos_reg),
        .wr_data (dur),
        .rd_en   (accept),
        .rd_addr (pos_reg),
        .rd_data (ram_rd_data)
    );

    assign oldest = hist_valid_reg[s1_pos_reg] ? ram_rd_data : fill_reg;
    assign dur    = s1_spike_reg ? newest_reg : s1_meas_reg;

    always_comb
    begin
        hist_valid_next = hist_valid_reg;
        fill_next       = fill_reg;
        newest_next     = newest_reg;
        window_sum_next = window_sum_reg;
        pred_next       = pred_reg;
        elapsed_next    = elapsed_reg;
        count_next      = count_reg;
        spike_next      = spike_reg;
        if (s1_go)
        begin
            if (s1_action_reg == fts_pkg::ACTION_RESTART)
            begin
                hist_valid_next = '0;
                fill_next       = default_duration_reg;
                newest_next     = default_duration_reg;
                window_sum_next = SW'(default_duration_reg) << PW;
                pred_next       = default_duration_reg;
                elapsed_next    = '0;
                count_next      = '0;
                spike_next      = 1'b0;
            end
            else
            begin
                hist_valid_next[s1_pos_reg] = 1'b1;
                newest_next     = dur;
                window_sum_next = window_sum_reg - SW'(oldest) + SW'(dur);
                pred_next       = DW'(window_sum_next >> PW);
                elapsed_next    = elapsed_reg + EW'(pred_next);
                count_next      = count_reg + DW'(1);
                spike_next      = s1_spike_reg;
            end
        end
    end

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_limit_reg       <= fts_pkg::PEAK_RESET;
            default_duration_reg <= fts_pkg::DEFAULT_RESET;
            pos_reg              <= '0;
            prev_tick_reg        <= '0;
            s1_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            hist_valid_reg       <= '0;
            fill_reg             <= fts_pkg::DEFAULT_RESET;
            newest_reg           <= fts_pkg::DEFAULT_RESET;
            window_sum_reg       <= SW'(fts_pkg::DEFAULT_RESET) << PW;
            pred_reg             <= fts_pkg::DEFAULT_RESET;
            elapsed_reg          <= '0;
            count_reg            <= '0;
            spike_reg            <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    fts_pkg::REG_PEAK_LIMIT:       peak_limit_reg       <= cfg_data;
                    fts_pkg::REG_DEFAULT_DURATION: default_duration_reg <= cfg_data;
                    default:                       ;
                endcase
            end
            if (accept)
            begin
                pos_reg       <= pos_next;
                prev_tick_reg <= tick;
            end
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            hist_valid_reg <= hist_valid_next;
            fill_reg       <= fill_next;
            newest_reg     <= newest_next;
            window_sum_reg <= window_sum_next;
            pred_reg       <= pred_next;
            elapsed_reg    <= elapsed_next;
            count_reg      <= count_next;
            spike_reg      <= spike_next;
        end
    end

    // working stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_action_reg <= action;
            s1_pos_reg    <= pos_reg;
            s1_spike_reg  <= (action == fts_pkg::ACTION_FRAME)
                             && (meas_ext > CW'(peak_limit_reg));
            s1_meas_reg   <= meas_ext[DW-1:0];
        end
    end

    assign out_valid          = out_valid_reg;
    assign predicted_duration = pred_reg;
    assign elapsed_time       = elapsed_reg;
    assign frame_count        = count_reg;
    assign spike_replaced     = spike_reg;

endmodule
